// File: hdl/progressive_accumulate_gamma_pack_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the progressive accumulation and gamma pack block
// Shared shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef PROGRESSIVE_ACCUMULATE_GAMMA_PACK_MACROS_SVH
`define PROGRESSIVE_ACCUMULATE_GAMMA_PACK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAGP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pagp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Progressive accumulation and gamma pack package
// Field widths, default parameters, channel order and the gamma table builder.
// ----------------------------------------------------------------------------
package pagp_pkg;

	localparam int unsigned DEF_PIXEL_INDEX_BITS     = 16;
	localparam int unsigned DEF_SAMPLE_FRACTION_BITS = 12;
	localparam int unsigned DEF_GAMMA_TABLE_BITS     = 10;

	localparam int unsigned INDEX_W  = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned PACK_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CHANNELS = 3;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [BYTE_W-1:0]  BYTE_MAX  = 8'hFF;
	localparam logic [BYTE_W-1:0]  ALPHA_BYTE = 8'hFF;

	// Gamma 1/2.2 is handled as the exponent pair 11/5 so the table can be
	// built with exact integer compares.
	localparam int unsigned GAMMA_EXP_NUM = 11;
	localparam int unsigned GAMMA_EXP_DEN = 5;
	localparam int unsigned BIG_W         = 160;

	// Largest v in 0..255 with (v/255)^(11/5) <= idx / 2^gbits, found by a
	// binary search over the byte. Evaluated only at elaboration.
	function automatic logic [BYTE_W-1:0] gamma_entry(input int unsigned idx,
	                                                  input int unsigned gbits);
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		logic [BYTE_W-1:0] v;
		logic [BYTE_W-1:0] cand;
		rhs = BIG_W'(1);
		for (int k = 0; k < GAMMA_EXP_NUM; k++) rhs = rhs * BIG_W'(BYTE_MAX);
		for (int k = 0; k < GAMMA_EXP_DEN; k++) rhs = rhs * BIG_W'(idx);
		v = '0;
		for (int b = BYTE_W - 1; b >= 0; b--) begin
			cand = v | (BYTE_W'(1) << b);
			lhs = BIG_W'(1);
			for (int k = 0; k < GAMMA_EXP_NUM; k++) lhs = lhs * BIG_W'(cand);
			lhs = lhs << (GAMMA_EXP_DEN * gbits);
			if (lhs <= rhs) v = cand;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// File: hdl/progressive_accumulate_gamma_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Progressive accumulation with gamma 2.2 RGBA8 packing
// Per-pixel sums live in one on-chip memory, averaged by a pipelined divider
// and mapped through a gamma ROM into packed RGBA8 results.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   sample   | sample_valid/sample_stall | pixel_index, sample_red/green/blue,
//            |                           | last_of_frame
//   result   | result_valid/result_stall | out_pixel_index, packed_rgba,
//            |                           | frame_end
//   config   | config_write              | config_data (accumulate enable)
//
// One item is taken per clock cycle while sample_stall is low. That rate is set
// by the single read-modify-write pass over the accumulation memory, with the
// write of one item forwarded to the next.
// arst_n clears the pipeline, sets the frame count to one and turns accumulation
// on. The sum memory is not cleared: the first frame overwrites it.
// A stalled result side fills an output queue; sample_stall rises only when
// every queue slot is spoken for by an item in flight.
// ----------------------------------------------------------------------------
module progressive_accumulate_gamma_pack
	import pagp_pkg::*;
#(
	parameter int unsigned PIXEL_INDEX_BITS     = DEF_PIXEL_INDEX_BITS,
	parameter int unsigned SAMPLE_FRACTION_BITS = DEF_SAMPLE_FRACTION_BITS,
	parameter int unsigned GAMMA_TABLE_BITS     = DEF_GAMMA_TABLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               config_write,
	input  logic               config_data,

	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [INDEX_W-1:0] pixel_index,
	input  logic [SAMPLE_W-1:0] sample_red,
	input  logic [SAMPLE_W-1:0] sample_green,
	input  logic [SAMPLE_W-1:0] sample_blue,
	input  logic               last_of_frame,

	output logic               result_valid,
	input  logic               result_stall,
	output logic [INDEX_W-1:0] out_pixel_index,
	output logic [PACK_W-1:0]  packed_rgba,
	output logic               frame_end
);

	localparam int unsigned ADDR_W     = PIXEL_INDEX_BITS;
	localparam int unsigned MEM_DEPTH  = 1 << ADDR_W;
	localparam int unsigned FRAC_W     = SAMPLE_FRACTION_BITS;
	localparam int unsigned GT_W       = GAMMA_TABLE_BITS;
	localparam int unsigned GT_SIZE    = 1 << GT_W;
	// One stage for the saturation check, then one quotient bit per stage.
	localparam int unsigned DIV_STAGES = FRAC_W + 1;
	// Covers every item between acceptance and the queue, plus slack.
	localparam int unsigned FIFO_DEPTH = FRAC_W + 6;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned OCC_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned PAD_W      = SUM_W + 1 - COUNT_W;

	typedef logic [CHANNELS-1:0][SUM_W-1:0]    word_t;
	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] samples_t;

	typedef struct packed {
		logic [SUM_W-1:0]  rem;
		logic [FRAC_W-1:0] quo;
		logic              sat;
	} lane_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        pix;
		logic                      last;
		logic [COUNT_W-1:0]        cnt;
		lane_t [CHANNELS-1:0]      lane;
	} div_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pix;
		logic [PACK_W-1:0]  rgba;
		logic               last;
	} result_t;

	// ------------------------------------------------------------------
	// Configuration and frame counter
	// ------------------------------------------------------------------
	logic               acc_en_q;
	logic [COUNT_W-1:0] count_q;
	logic               accept;
	logic               pop;
	logic [OCC_W-1:0]   occ_q;

	assign sample_stall = (occ_q == OCC_W'(FIFO_DEPTH));
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_q <= 1'b1;
		end else if (config_write) begin
			acc_en_q <= config_data;
		end
	end

	// The count moves after the last pixel of a frame; the item itself keeps
	// the value it saw at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_ONE;
		end else if (accept && last_of_frame) begin
			if (!acc_en_q) begin
				count_q <= COUNT_ONE;
			end else if (count_q != COUNT_MAX) begin
				count_q <= count_q + COUNT_ONE;
			end
		end
	end

	// ------------------------------------------------------------------
	// Address forming: the index is masked to the memory depth, and the
	// reported index is that masked value in 16 bits.
	// ------------------------------------------------------------------
	logic [ADDR_W+INDEX_W-1:0] pix_wide;
	logic [ADDR_W-1:0]         addr_in;
	logic [ADDR_W+INDEX_W-1:0] addr_wide;
	samples_t                  samp_in;

	assign pix_wide  = {{ADDR_W{1'b0}}, pixel_index};
	assign addr_in   = pix_wide[ADDR_W-1:0];
	assign addr_wide = {{INDEX_W{1'b0}}, addr_in};
	assign samp_in   = {sample_blue, sample_green, sample_red};

	// ------------------------------------------------------------------
	// Stage 1: memory read data arrives, the new sums are formed and
	// written back in the same cycle.
	// ------------------------------------------------------------------
	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [INDEX_W-1:0] pix_s1;
	logic               last_s1;
	logic [COUNT_W-1:0] cnt_s1;
	logic               first_s1;
	samples_t           samp_s1;
	logic               fwd_hit_s1;
	word_t              fwd_sum_s1;

	word_t              acc_mem [MEM_DEPTH];
	word_t              rd_word_q;
	word_t              new_sum;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_mem[addr_s1] <= new_sum;
		end
		if (accept) begin
			rd_word_q <= acc_mem[addr_in];
		end
	end

	// The memory returns old data when the item ahead writes the same entry
	// on the edge of this read, so that write is carried along instead.
	always_comb begin
		logic [SUM_W-1:0] old_sum;
		logic [SUM_W-1:0] ext;
		logic [SUM_W:0]   total;
		new_sum = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			old_sum = fwd_hit_s1 ? fwd_sum_s1[c] : rd_word_q[c];
			ext     = {{(SUM_W - SAMPLE_W){1'b0}}, samp_s1[c]};
			total   = {1'b0, old_sum} + {1'b0, ext};
			if (first_s1) begin
				new_sum[c] = ext;
			end else if (total[SUM_W]) begin
				new_sum[c] = '1;
			end else begin
				new_sum[c] = total[SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= addr_in;
		pix_s1     <= addr_wide[INDEX_W-1:0];
		last_s1    <= last_of_frame;
		cnt_s1     <= count_q;
		first_s1   <= (count_q == COUNT_ONE);
		samp_s1    <= samp_in;
		fwd_hit_s1 <= valid_s1 && (addr_s1 == addr_in);
		fwd_sum_s1 <= new_sum;
	end

	// ------------------------------------------------------------------
	// Stage 2: registered sums ahead of the divider.
	// ------------------------------------------------------------------
	logic               valid_s2;
	word_t              sum_s2;
	logic [INDEX_W-1:0] pix_s2;
	logic               last_s2;
	logic [COUNT_W-1:0] cnt_s2;

	always_ff @(posedge clk) begin
		sum_s2  <= new_sum;
		pix_s2  <= pix_s1;
		last_s2 <= last_s1;
		cnt_s2  <= cnt_s1;
	end

	// ------------------------------------------------------------------
	// Divider stages: the first checks avg >= 1.0, each later stage
	// settles one quotient bit, most significant first. Once the sum is
	// known below count * 2^FRAC_W the quotient fits in FRAC_W bits.
	// ------------------------------------------------------------------
	div_t div_s3       [DIV_STAGES];
	logic div_valid_s3 [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		div_t stage_next;
		logic valid_in;

		if (j == 0) begin : g_head
			assign valid_in = valid_s2;
			always_comb begin
				logic [SUM_W:0] limit;
				limit = {{PAD_W{1'b0}}, cnt_s2} << FRAC_W;
				stage_next      = '0;
				stage_next.pix  = pix_s2;
				stage_next.last = last_s2;
				stage_next.cnt  = cnt_s2;
				for (int c = 0; c < CHANNELS; c++) begin
					stage_next.lane[c].rem = sum_s2[c];
					stage_next.lane[c].quo = '0;
					stage_next.lane[c].sat = ({1'b0, sum_s2[c]} >= limit);
				end
			end
		end else begin : g_bit
			localparam int unsigned BIT = DIV_STAGES - 1 - j;
			assign valid_in = div_valid_s3[j-1];
			always_comb begin
				logic [SUM_W:0] dsh;
				logic [SUM_W:0] trial;
				stage_next = div_s3[j-1];
				dsh = {{PAD_W{1'b0}}, div_s3[j-1].cnt} << BIT;
				for (int c = 0; c < CHANNELS; c++) begin
					trial = {1'b0, div_s3[j-1].lane[c].rem} - dsh;
					if (!trial[SUM_W]) begin
						stage_next.lane[c].rem      = trial[SUM_W-1:0];
						stage_next.lane[c].quo[BIT] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s3[j] <= 1'b0;
			end else begin
				div_valid_s3[j] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			div_s3[j] <= stage_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: gamma ROM lookup, registered. The average is rescaled to
	// the table's fraction bits by dropping or appending low bits.
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0]  gamma_rom [GT_SIZE];
	logic [BYTE_W-1:0]  byte_s4   [CHANNELS];
	logic               valid_s4;
	logic [INDEX_W-1:0] pix_s4;
	logic               last_s4;

	for (genvar i = 0; i < GT_SIZE; i++) begin : g_rom
		localparam logic [BYTE_W-1:0] ENTRY = gamma_entry(i, GT_W);
		assign gamma_rom[i] = ENTRY;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic [GT_W-1:0] idx;
		if (FRAC_W >= GT_W) begin : g_shr
			assign idx = div_s3[DIV_STAGES-1].lane[c].quo[FRAC_W-1 -: GT_W];
		end else begin : g_shl
			assign idx = {div_s3[DIV_STAGES-1].lane[c].quo, {(GT_W - FRAC_W){1'b0}}};
		end

		always_ff @(posedge clk) begin
			if (div_s3[DIV_STAGES-1].lane[c].sat) begin
				byte_s4[c] <= BYTE_MAX;
			end else begin
				byte_s4[c] <= gamma_rom[idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s4  <= div_s3[DIV_STAGES-1].pix;
		last_s4 <= div_s3[DIV_STAGES-1].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s4 <= div_valid_s3[DIV_STAGES-1];
		end
	end

	// ------------------------------------------------------------------
	// Output queue. The pipeline never halts; occ_q counts every item
	// accepted and not yet delivered, so the queue cannot overflow.
	// ------------------------------------------------------------------
	result_t            fifo_mem [FIFO_DEPTH];
	result_t            fifo_wr;
	result_t            fifo_head;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [OCC_W-1:0]   fifo_cnt_q;

	assign fifo_wr.pix  = pix_s4;
	assign fifo_wr.rgba = {ALPHA_BYTE, byte_s4[CH_BLUE], byte_s4[CH_GREEN], byte_s4[CH_RED]};
	assign fifo_wr.last = last_s4;

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			fifo_mem[wr_ptr_q] <= fifo_wr;
		end
	end

	assign fifo_head       = fifo_mem[rd_ptr_q];
	assign result_valid    = (fifo_cnt_q != '0);
	assign out_pixel_index = fifo_head.pix;
	assign packed_rgba     = fifo_head.rgba;
	assign frame_end       = fifo_head.last;
	assign pop             = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			occ_q      <= '0;
		end else begin
			if (valid_s4) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({valid_s4, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + OCC_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - OCC_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({accept, pop})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/pagp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the progressive accumulation and gamma pack block
// Watches the result handshake, the alpha byte and the input stall.
// ----------------------------------------------------------------------------
`include "progressive_accumulate_gamma_pack_macros.svh"

module pagp_checker
	import pagp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic [INDEX_W-1:0] out_pixel_index,
	input logic [PACK_W-1:0]  packed_rgba,
	input logic               frame_end
);

	// A waiting result stays offered and unchanged.
	`PAGP_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid, "result dropped while stalled")
	`PAGP_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && result_stall, $stable(packed_rgba) && $stable(out_pixel_index) && $stable(frame_end), "result changed while stalled")

	// Every packed color carries an opaque alpha byte.
	`PAGP_ASSERT_IMPLY(a_alpha_opaque, clk, arst_n, result_valid, packed_rgba[PACK_W-1 -: BYTE_W] == ALPHA_BYTE, "alpha byte not opaque")

	// The input only becomes blocked right after it took an item.
	`PAGP_ASSERT_IMPLY(a_stall_after_accept, clk, arst_n, $rose(sample_stall), $past(sample_valid && !sample_stall), "input stall rose without an accepted item")

endmodule

bind progressive_accumulate_gamma_pack pagp_checker u_pagp_checker (.*);
`default_nettype wire
